[hw/rtl/ffpra_pkg.sv]
// shared constants, types and codes of the first-fit page region allocator
package ffpra_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int PAGE_BITS   = 40;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_ADD   = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_e_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOFIT    = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_ZERO     = 3'd4
  } status_e_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_RESP
  } state_e_t;

  typedef struct packed {
    logic                 we;
    logic                 set;
    logic                 clr;
    logic [IDX_W-1:0]     idx;
    logic [PAGE_BITS-1:0] start;
    logic [PAGE_BITS-1:0] count;
  } tbl_wr_t;

  typedef struct packed {
    logic                 valid;
    logic [PAGE_BITS-1:0] start;
    logic [PAGE_BITS-1:0] count;
  } tbl_rd_t;

endpackage

[hw/rtl/ffpra_if.sv]
// item channels of the allocator: command in, status out
interface ffpra_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     cmd;
  logic [ffpra_pkg::PAGE_BITS-1:0] page_num;
  logic [ffpra_pkg::PAGE_BITS-1:0] num_pages;

  modport source (output valid, cmd, page_num, num_pages, input ready);
  modport sink   (input valid, cmd, page_num, num_pages, output ready);
endinterface

interface ffpra_out_if;
  logic                           valid;
  logic                           ready;
  logic [2:0]                     status;
  logic [ffpra_pkg::PAGE_BITS-1:0] start_page;
  logic [ffpra_pkg::PAGE_BITS-1:0] page_total;

  modport source (output valid, status, start_page, page_total, input ready);
  modport sink   (input valid, status, start_page, page_total, output ready);
endinterface

[hw/rtl/ffpra_alu.sv]
// shared add / subtract unit with borrow out
module ffpra_alu (
  input  logic [ffpra_pkg::PAGE_BITS-1:0] a,
  input  logic [ffpra_pkg::PAGE_BITS-1:0] b,
  input  logic                            sub,
  output logic [ffpra_pkg::PAGE_BITS:0]   res
);
  import ffpra_pkg::*;

  assign res = {1'b0, a} + ({1'b0, b} ^ {(PAGE_BITS + 1){sub}}) + (PAGE_BITS + 1)'(sub);

endmodule

[hw/rtl/ffpra_table.sv]
// region table: valid flags plus start/count memory with registered read
module ffpra_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ffpra_pkg::IDX_W-1:0] rd_idx,
  output ffpra_pkg::tbl_rd_t          rd,
  input  ffpra_pkg::tbl_wr_t          wr
);
  import ffpra_pkg::*;

  logic [TABLE_DEPTH-1:0]           valid_r;
  logic [2*PAGE_BITS-1:0]           mem_r [TABLE_DEPTH];
  logic                             rd_valid_r;
  logic [2*PAGE_BITS-1:0]           rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.set) begin
      valid_r[wr.idx] <= 1'b1;
    end else if (wr.clr) begin
      valid_r[wr.idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem_r[wr.idx] <= {wr.start, wr.count};
    end
    rd_data_r  <= mem_r[rd_idx];
    rd_valid_r <= valid_r[rd_idx];
  end

  assign rd.valid = rd_valid_r;
  assign rd.start = rd_data_r[2*PAGE_BITS-1:PAGE_BITS];
  assign rd.count = rd_data_r[PAGE_BITS-1:0];

endmodule

[hw/rtl/ffpra_ctrl.sv]
// command sequencer: table scan, update and result register
module ffpra_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  ffpra_in_if.sink                    in_ch,
  ffpra_out_if.source                 out_ch,
  output logic [ffpra_pkg::IDX_W-1:0] rd_idx,
  input  ffpra_pkg::tbl_rd_t          free_rd,
  input  ffpra_pkg::tbl_rd_t          used_rd,
  output ffpra_pkg::tbl_wr_t          free_wr,
  output ffpra_pkg::tbl_wr_t          used_wr
);
  import ffpra_pkg::*;

  state_e_t             state_r, state_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic                 chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]     chk_idx_r;
  cmd_e_t               cmd_r, cmd_nxt;
  logic [PAGE_BITS-1:0] pg_r, pg_nxt;
  logic [PAGE_BITS-1:0] np_r, np_nxt;
  logic                 hit_found_r, hit_found_nxt;
  logic [IDX_W-1:0]     hit_idx_r, hit_idx_nxt;
  logic [PAGE_BITS-1:0] hit_start_r, hit_start_nxt;
  logic [PAGE_BITS-1:0] hit_count_r, hit_count_nxt;
  logic                 slot_found_r, slot_found_nxt;
  logic [IDX_W-1:0]     slot_idx_r, slot_idx_nxt;
  status_e_t            out_status_r, out_status_nxt;
  logic [PAGE_BITS-1:0] out_start_r, out_start_nxt;
  logic [PAGE_BITS-1:0] out_total_r, out_total_nxt;

  logic [PAGE_BITS-1:0] alu_a, alu_b;
  logic                 alu_sub;
  logic [PAGE_BITS:0]   alu_res;
  logic                 in_acc, out_acc, scan_done, slot_empty, np_zero;

  ffpra_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu_res)
  );

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign out_acc   = out_ch.valid && out_ch.ready;
  assign scan_done = (idx_r == CNT_W'(TABLE_DEPTH));
  assign rd_idx    = idx_r[IDX_W-1:0];
  assign np_zero   = (np_r == '0);
  assign slot_empty = (cmd_r == CMD_ALLOC) ? !used_rd.valid : !free_rd.valid;

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = (state_r == S_RESP);
  assign out_ch.status     = out_status_r;
  assign out_ch.start_page = out_start_r;
  assign out_ch.page_total = out_total_r;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    chk_vld_nxt    = 1'b0;
    cmd_nxt        = cmd_r;
    pg_nxt         = pg_r;
    np_nxt         = np_r;
    hit_found_nxt  = hit_found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_start_nxt  = hit_start_r;
    hit_count_nxt  = hit_count_r;
    slot_found_nxt = slot_found_r;
    slot_idx_nxt   = slot_idx_r;
    out_status_nxt = out_status_r;
    out_start_nxt  = out_start_r;
    out_total_nxt  = out_total_r;
    free_wr        = '0;
    used_wr        = '0;
    alu_sub        = 1'b1;
    alu_a          = (cmd_r == CMD_ALLOC) ? free_rd.count : used_rd.start;
    alu_b          = (cmd_r == CMD_ALLOC) ? np_r : pg_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt        = cmd_e_t'(in_ch.cmd);
          pg_nxt         = in_ch.page_num;
          np_nxt         = in_ch.num_pages;
          idx_nxt        = '0;
          hit_found_nxt  = 1'b0;
          slot_found_nxt = 1'b0;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!scan_done) begin
          idx_nxt     = idx_r + CNT_W'(1);
          chk_vld_nxt = 1'b1;
        end else begin
          state_nxt = S_APPLY;
        end
        if (chk_vld_r) begin
          if (!slot_found_r && slot_empty) begin
            slot_found_nxt = 1'b1;
            slot_idx_nxt   = chk_idx_r;
          end
          if (!hit_found_r && cmd_r == CMD_ALLOC && free_rd.valid && !alu_res[PAGE_BITS]) begin
            hit_found_nxt = 1'b1;
            hit_idx_nxt   = chk_idx_r;
            hit_start_nxt = free_rd.start;
            hit_count_nxt = alu_res[PAGE_BITS-1:0];
          end
          if (!hit_found_r && cmd_r == CMD_FREE && used_rd.valid
              && alu_res[PAGE_BITS-1:0] == '0) begin
            hit_found_nxt = 1'b1;
            hit_idx_nxt   = chk_idx_r;
            hit_start_nxt = used_rd.start;
            hit_count_nxt = used_rd.count;
          end
        end
      end
      S_APPLY: begin
        alu_a          = hit_start_r;
        alu_b          = np_r;
        alu_sub        = 1'b0;
        state_nxt      = S_RESP;
        out_status_nxt = ST_OK;
        out_start_nxt  = '0;
        out_total_nxt  = '0;
        unique case (cmd_r)
          CMD_ALLOC: begin
            if (np_zero) begin
              out_status_nxt = ST_ZERO;
            end else if (!hit_found_r) begin
              out_status_nxt = ST_NOFIT;
            end else if (!slot_found_r) begin
              out_status_nxt = ST_FULL;
            end else begin
              used_wr.we    = 1'b1;
              used_wr.set   = 1'b1;
              used_wr.idx   = slot_idx_r;
              used_wr.start = hit_start_r;
              used_wr.count = np_r;
              free_wr.we    = 1'b1;
              free_wr.clr   = (hit_count_r == '0);
              free_wr.idx   = hit_idx_r;
              free_wr.start = alu_res[PAGE_BITS-1:0];
              free_wr.count = hit_count_r;
              out_start_nxt = hit_start_r;
              out_total_nxt = np_r;
            end
          end
          CMD_FREE: begin
            if (!hit_found_r) begin
              out_status_nxt = ST_NOTFOUND;
            end else if (!slot_found_r) begin
              out_status_nxt = ST_FULL;
            end else begin
              free_wr.we    = 1'b1;
              free_wr.set   = 1'b1;
              free_wr.idx   = slot_idx_r;
              free_wr.start = hit_start_r;
              free_wr.count = hit_count_r;
              used_wr.clr   = 1'b1;
              used_wr.idx   = hit_idx_r;
              out_start_nxt = hit_start_r;
              out_total_nxt = hit_count_r;
            end
          end
          CMD_ADD: begin
            if (np_zero) begin
              out_status_nxt = ST_ZERO;
            end else if (!slot_found_r) begin
              out_status_nxt = ST_FULL;
            end else begin
              free_wr.we    = 1'b1;
              free_wr.set   = 1'b1;
              free_wr.idx   = slot_idx_r;
              free_wr.start = pg_r;
              free_wr.count = np_r;
              out_start_nxt = pg_r;
              out_total_nxt = np_r;
            end
          end
          default: begin
            out_status_nxt = ST_NOTFOUND;
          end
        endcase
      end
      S_RESP: begin
        if (out_acc) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      chk_vld_r    <= 1'b0;
      hit_found_r  <= 1'b0;
      slot_found_r <= 1'b0;
      idx_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      chk_vld_r    <= chk_vld_nxt;
      hit_found_r  <= hit_found_nxt;
      slot_found_r <= slot_found_nxt;
      idx_r        <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r    <= idx_r[IDX_W-1:0];
    cmd_r        <= cmd_nxt;
    pg_r         <= pg_nxt;
    np_r         <= np_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_start_r  <= hit_start_nxt;
    hit_count_r  <= hit_count_nxt;
    slot_idx_r   <= slot_idx_nxt;
    out_status_r <= out_status_nxt;
    out_start_r  <= out_start_nxt;
    out_total_r  <= out_total_nxt;
  end

`ifndef SYNTHESIS
  a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_SCAN) && (idx_r == '0))
    else $error("scan did not start at entry zero");

  a_wr_in_apply: assert property (@(posedge clk) disable iff (!rst_n)
    (free_wr.we || used_wr.we || free_wr.set || used_wr.clr) |-> (state_r == S_APPLY))
    else $error("table update outside apply step");

  a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && out_status_r == ST_OK) |-> (out_total_r != '0))
    else $error("ok result with zero page total");

  a_set_clr: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({free_wr.set, free_wr.clr}))
    else $error("free entry set and cleared together");
`endif

endmodule

[hw/rtl/first_fit_page_region_allocator.sv]
// top level of the first-fit page region allocator
// a command item runs through a scan of every table entry, an apply step and the result state
// a new command item is taken only while idle, after the previous result item has been accepted
// the scan is one pass over both tables, one entry a cycle on their read ports
// reset: synchronous, active low; clears both valid vectors at once, no clearing pass
module first_fit_page_region_allocator (
  input logic         clk,
  input logic         rst_n,
  ffpra_in_if.sink    in_ch,
  ffpra_out_if.source out_ch
);
  import ffpra_pkg::*;

  logic [IDX_W-1:0] rd_idx;
  tbl_rd_t          free_rd, used_rd;
  tbl_wr_t          free_wr, used_wr;

  ffpra_table u_free_tbl (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_idx (rd_idx),
    .rd     (free_rd),
    .wr     (free_wr)
  );

  ffpra_table u_used_tbl (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_idx (rd_idx),
    .rd     (used_rd),
    .wr     (used_wr)
  );

  ffpra_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .rd_idx  (rd_idx),
    .free_rd (free_rd),
    .used_rd (used_rd),
    .free_wr (free_wr),
    .used_wr (used_wr)
  );

endmodule

[tb/sv/first_fit_page_region_allocator_tb.sv]
// testbench of the first-fit page region allocator: predicts and checks every item
`timescale 1ns / 100ps

module first_fit_page_region_allocator_tb;
  import ffpra_pkg::*;

  localparam int  N_RANDOM     = 1080;
  localparam int  DRAIN_CYCLES = TABLE_DEPTH + 40;
  localparam int  RUN_LIMIT_NS = 6_000_000;

  typedef logic [PAGE_BITS-1:0] page_t;

  typedef struct packed {
    status_e_t status;
    page_t     start;
    page_t     total;
  } answer_t;

  class region_scoreboard_t;
    bit      free_ok   [TABLE_DEPTH];
    page_t   free_base [TABLE_DEPTH];
    page_t   free_len  [TABLE_DEPTH];
    bit      used_ok   [TABLE_DEPTH];
    page_t   used_base [TABLE_DEPTH];
    page_t   used_len  [TABLE_DEPTH];
    answer_t awaited_answers[$];
    int      mismatches;
    int      answered;
    int      status_hits[5];

    function answer_t predict(cmd_e_t c, page_t pg, page_t np);
      answer_t a;
      int      f;
      int      u;
      a.status = ST_NOTFOUND;
      a.start  = '0;
      a.total  = '0;
      f = -1;
      u = -1;
      case (c)
        CMD_ALLOC: begin
          if (np == '0) begin
            a.status = ST_ZERO;
          end else begin
            for (int i = 0; i < TABLE_DEPTH; i++)
              if (f < 0 && free_ok[i] && free_len[i] >= np) f = i;
            for (int i = 0; i < TABLE_DEPTH; i++)
              if (u < 0 && !used_ok[i]) u = i;
            if (f < 0) begin
              a.status = ST_NOFIT;
            end else if (u < 0) begin
              a.status = ST_FULL;
            end else begin
              used_ok[u]   = 1'b1;
              used_base[u] = free_base[f];
              used_len[u]  = np;
              free_base[f] = free_base[f] + np;
              free_len[f]  = free_len[f] - np;
              if (free_len[f] == '0) free_ok[f] = 1'b0;
              a.status = ST_OK;
              a.start  = used_base[u];
              a.total  = np;
            end
          end
        end
        CMD_FREE: begin
          for (int i = 0; i < TABLE_DEPTH; i++)
            if (u < 0 && used_ok[i] && used_base[i] == pg) u = i;
          for (int i = 0; i < TABLE_DEPTH; i++)
            if (f < 0 && !free_ok[i]) f = i;
          if (u < 0) begin
            a.status = ST_NOTFOUND;
          end else if (f < 0) begin
            a.status = ST_FULL;
          end else begin
            free_ok[f]   = 1'b1;
            free_base[f] = used_base[u];
            free_len[f]  = used_len[u];
            used_ok[u]   = 1'b0;
            a.status = ST_OK;
            a.start  = free_base[f];
            a.total  = free_len[f];
          end
        end
        CMD_ADD: begin
          for (int i = 0; i < TABLE_DEPTH; i++)
            if (f < 0 && !free_ok[i]) f = i;
          if (np == '0) begin
            a.status = ST_ZERO;
          end else if (f < 0) begin
            a.status = ST_FULL;
          end else begin
            free_ok[f]   = 1'b1;
            free_base[f] = pg;
            free_len[f]  = np;
            a.status = ST_OK;
            a.start  = pg;
            a.total  = np;
          end
        end
        default: a.status = ST_NOTFOUND;
      endcase
      return a;
    endfunction

    function void note_command(cmd_e_t c, page_t pg, page_t np);
      awaited_answers.push_back(predict(c, pg, np));
    endfunction

    function void check_answer(logic [2:0] st, page_t sp, page_t pt);
      answer_t e;
      answered++;
      if (st < 5) status_hits[st]++;
      if (awaited_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected status item %0d: status %0d start %h pages %h",
                   answered, st, sp, pt);
      end else begin
        e = awaited_answers.pop_front();
        if (st !== e.status || sp !== e.start || pt !== e.total) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch on item %0d: status exp %0d got %0d, ",
                      "start exp %h got %h, pages exp %h got %h"},
                     answered, e.status, st, e.start, sp, e.total, pt);
        end
      end
    endfunction

    function int pending();
      return awaited_answers.size();
    endfunction

    // start of a random live allocation, or a random page when none is live
    function page_t pick_used_start();
      int    live[$];
      logic [63:0] w;
      foreach (used_ok[i]) if (used_ok[i]) live.push_back(i);
      if (live.size() == 0) begin
        w = {$urandom(), $urandom()};
        return w[PAGE_BITS-1:0];
      end
      return used_base[live[$urandom_range(0, live.size() - 1)]];
    endfunction

    // a request of exactly this size empties the lowest free entry
    function page_t lowest_free_len();
      for (int i = 0; i < TABLE_DEPTH; i++)
        if (free_ok[i]) return free_len[i];
      return page_t'(1);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   no_idle;
  int   sent;

  ffpra_in_if  in_ch ();
  ffpra_out_if out_ch ();

  region_scoreboard_t sb;

  first_fit_page_region_allocator i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

  function automatic page_t rand_page();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[PAGE_BITS-1:0];
  endfunction

  function automatic page_t pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 50) return page_t'($urandom_range(1, 16));
    if (r < 85) return rand_page() >> $urandom_range(0, PAGE_BITS - 1);
    if (r < 95) return rand_page();
    return '1;
  endfunction

  task automatic send_item(cmd_e_t c, page_t pg, page_t np);
    @(negedge clk);
    while (!no_idle && $urandom_range(0, 99) < 14) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= c;
    in_ch.page_num  <= pg;
    in_ch.num_pages <= np;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_command(c, pg, np);
    sent++;
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 14);
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      sb.check_answer(out_ch.status, out_ch.start_page, out_ch.page_total);
  end

  initial begin
    int      mode;
    int      r;
    int      w_exact;
    int      w_alloc;
    int      w_free;
    int      w_add;
    cmd_e_t  c;
    page_t   pg;
    page_t   np;

    sb = new();
    rst_n           = 1'b0;
    no_idle         = 1'b0;
    sent            = 0;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = CMD_ALLOC;
    in_ch.page_num  = '0;
    in_ch.num_pages = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // corner cases on an empty allocator
    send_item(CMD_RSVD, '1, '1);
    send_item(CMD_ALLOC, rand_page(), '0);
    send_item(CMD_ADD, rand_page(), '0);
    send_item(CMD_ALLOC, '0, page_t'(5));
    send_item(CMD_FREE, page_t'(123), '1);
    // carving past the top page wraps the start
    send_item(CMD_ADD, '1 - page_t'(1), page_t'(5));
    send_item(CMD_ALLOC, '0, page_t'(3));
    send_item(CMD_ALLOC, '1, page_t'(2));
    send_item(CMD_ALLOC, '0, page_t'(1));
    // duplicate regions give duplicate used starts
    send_item(CMD_ADD, page_t'(100), page_t'(4));
    send_item(CMD_ADD, page_t'(100), page_t'(4));
    send_item(CMD_ADD, '0, '1);
    send_item(CMD_ALLOC, '0, page_t'(4));
    send_item(CMD_ALLOC, '0, page_t'(4));
    send_item(CMD_FREE, page_t'(100), '0);
    send_item(CMD_FREE, page_t'(100), '0);
    send_item(CMD_FREE, page_t'(100), '0);
    send_item(CMD_FREE, '1 - page_t'(1), '0);
    send_item(CMD_FREE, page_t'(1), '0);
    send_item(CMD_ALLOC, '0, '1);
    send_item(CMD_ALLOC, '0, '1);
    send_item(CMD_FREE, '0, '1);
    send_item(CMD_FREE, '1, '0);
    hold_until_drained();

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 250 == 249) hold_until_drained();
      no_idle = (n >= 400 && n < 560);
      mode = (n / 90) % 4;
      case (mode)
        0: begin w_exact = 0;  w_alloc = 35; w_free = 30; w_add = 25; end
        1: begin w_exact = 0;  w_alloc = 25; w_free = 10; w_add = 60; end
        2: begin w_exact = 0;  w_alloc = 80; w_free = 10; w_add = 8;  end
        default: begin w_exact = 25; w_alloc = 5; w_free = 60; w_add = 5; end
      endcase
      r  = $urandom_range(0, 99);
      pg = rand_page();
      np = rand_page();
      if (r < w_exact) begin
        c  = CMD_ALLOC;
        np = sb.lowest_free_len();
      end else if (r < w_exact + w_alloc) begin
        c  = CMD_ALLOC;
        np = (mode == 2 || $urandom_range(0, 1) == 0) ? page_t'($urandom_range(1, 8))
                                                     : pick_size();
      end else if (r < w_exact + w_alloc + w_free) begin
        c = CMD_FREE;
        if ($urandom_range(0, 9) < 8) pg = sb.pick_used_start();
      end else if (r < w_exact + w_alloc + w_free + w_add) begin
        c  = CMD_ADD;
        np = pick_size();
        // sometimes overlap a live allocation
        if ($urandom_range(0, 4) == 0) pg = sb.pick_used_start();
      end else begin
        c  = cmd_e_t'($urandom_range(0, 3));
        np = ($urandom_range(0, 1) == 0) ? '0 : pick_size();
      end
      send_item(c, pg, np);
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d command items, %0d status items: ok %0d, no fit %0d, table full %0d",
             sent, sb.answered, sb.status_hits[ST_OK], sb.status_hits[ST_NOFIT],
             sb.status_hits[ST_FULL]);
    $display("not found %0d, zero size %0d, mismatches %0d",
             sb.status_hits[ST_NOTFOUND], sb.status_hits[ST_ZERO], sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
